// ===== rtl/core/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-tagger mistag coefficient: shared package
// Register indexes and reset values, fixed-point widths, coefficient modes,
// tag decision decoding and the saturation helpers used by all stages.
// ----------------------------------------------------------------------------
package tmc_pkg;

   localparam int DATA_WIDTH_DEF = 16;

   // Configuration register file.
   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_OS_OFFSET       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OS_SLOPE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OS_OFFSET_DELTA = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OS_SLOPE_DELTA  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SS_OFFSET       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SS_SLOPE        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SS_OFFSET_DELTA = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SS_SLOPE_DELTA  = 3'd7;

   localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
      32'd6554, 32'd16384, 32'd0, 32'd0,
      32'd6554, 32'd16384, 32'd0, 32'd0
   };

   // Fixed-point widths.
   localparam int MISTAG_W = 15;
   localparam int CAL_W    = 20;   // calibrated mistag, Q.16
   localparam int MIX_W    = 48;   // tagger combination, Q.32
   localparam int RES_W    = 32;
   localparam int SAT_IN_W = 80;   // widest value handed to a saturation

   localparam logic [MISTAG_W-1:0]     HALF_Q14 = 15'd8192;
   localparam logic signed [CAL_W-1:0] HALF_Q16 = 20'sd32768;
   localparam logic signed [MIX_W-1:0] ONE_Q32  = 48'sh0001_0000_0000;

   // Tag decision codes; the pattern 2'b10 is read as untagged.
   localparam logic [1:0] DEC_PLUS  = 2'b01;
   localparam logic [1:0] DEC_MINUS = 2'b11;

   typedef enum logic [1:0] {
      MODE_SIN  = 2'd0,
      MODE_COS  = 2'd1,
      MODE_SINH = 2'd2,
      MODE_COSH = 2'd3
   } mode_type;

   typedef struct packed {
      logic nonzero;
      logic negative;
   } tag_sel_type;

   function automatic tag_sel_type decode_tag(input logic [1:0] code);
      tag_sel_type t;
      unique case (code)
         DEC_PLUS:  t = '{nonzero: 1'b1, negative: 1'b0};
         DEC_MINUS: t = '{nonzero: 1'b1, negative: 1'b1};
         default:   t = '{nonzero: 1'b0, negative: 1'b0};
      endcase
      return t;
   endfunction

   function automatic tag_sel_type neg_tag(input tag_sel_type t);
      return '{nonzero: t.nonzero, negative: ~t.negative};
   endfunction

   // Multiplies a value by a decision of -1, 0 or +1.
   function automatic logic signed [MIX_W-1:0] apply_tag(
      input tag_sel_type t, input logic signed [MIX_W-1:0] v);
      logic signed [MIX_W-1:0] r;
      if (!t.nonzero) begin
         r = '0;
      end else if (t.negative) begin
         r = -v;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [CAL_W-1:0] sat_cal(input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-CAL_W:0] hi_bits;
      logic signed [CAL_W-1:0] r;
      hi_bits = v[SAT_IN_W-1:CAL_W-1];
      if (&hi_bits || ~|hi_bits) begin
         r = v[CAL_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         r = {1'b1, {(CAL_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(CAL_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [RES_W-1:0] sat_res(input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-RES_W:0] hi_bits;
      logic signed [RES_W-1:0] r;
      hi_bits = v[SAT_IN_W-1:RES_W-1];
      if (&hi_bits || ~|hi_bits) begin
         r = v[RES_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         r = {1'b1, {(RES_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(RES_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/tmc_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// Pipeline stage control
// Valid bits for a chain of register stages with per-stage load enables, so
// that empty stages fill up while the output is stalled.
// ----------------------------------------------------------------------------
module tmc_pipe_ctl #(
   parameter int STAGES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              i_valid,
   output logic              i_ready,
   output logic              o_valid,
   input  logic              o_ready,
   output logic [STAGES-1:0] ld
);

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;

   // A stage may load when it is empty or when its word moves on.
   always_comb begin
      ld[STAGES-1] = !vld_ff[STAGES-1] || o_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (ld[0]) begin
         vld_in[0] = i_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ld[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign i_ready = ld[0];
   assign o_valid = vld_ff[STAGES-1];

`ifndef ASSERT_OFF
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      i_valid && i_ready |=> vld_ff[0])
      else $error("accepted word did not enter the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !o_ready |-> !i_ready)
      else $error("full pipeline accepts a word while stalled");

   a_first_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !ld[0] |=> vld_ff[0])
      else $error("stalled word lost in the first stage");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(vld_ff) == $countones($past(vld_ff))
         + int'($past(i_valid && i_ready)) - int'($past(o_valid && o_ready)))
      else $error("words created or lost inside the pipeline");
`endif

endmodule

// ===== rtl/core/tmc_calib.sv =====
// ----------------------------------------------------------------------------
// Tagger calibration datapath
// Three stages: difference to the mean mistag, the three slope products,
// then offsets, rounding to Q.16, saturation and the forced one-half case.
// ----------------------------------------------------------------------------
module tmc_calib #(
   parameter int DATA_WIDTH = tmc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic [2:0]                          ld,
   input  logic [tmc_pkg::MISTAG_W-1:0]        mistag,
   input  logic [tmc_pkg::MISTAG_W-1:0]        mean_mistag,
   input  logic signed [DATA_WIDTH-1:0]        offset,
   input  logic signed [DATA_WIDTH-1:0]        slope,
   input  logic signed [DATA_WIDTH-1:0]        offset_delta,
   input  logic signed [DATA_WIDTH-1:0]        slope_delta,
   output logic signed [tmc_pkg::CAL_W-1:0]    cal_b,
   output logic signed [tmc_pkg::CAL_W-1:0]    cal_bb
);
   import tmc_pkg::*;

   localparam int DW  = MISTAG_W + 1;
   localparam int KW  = DATA_WIDTH + 2;
   localparam int MW  = DATA_WIDTH + DW;
   localparam int BPW = KW + DW;
   localparam int MCW = DATA_WIDTH + DW + 2;
   localparam int BRW = BPW + 2;
   localparam logic signed [MCW-1:0] MEAN_LIMIT = MCW'(32'sd134217728);

   // Stage 0.
   logic signed [DW-1:0]         d_ff;
   logic                         eta_hi_ff;
   logic signed [DATA_WIDTH-1:0] p0_ff;
   logic signed [DATA_WIDTH-1:0] p1_ff;
   logic signed [KW-1:0]         b0_ff;
   logic signed [KW-1:0]         bb0_ff;
   logic signed [KW-1:0]         b1_ff;
   logic signed [KW-1:0]         bb1_ff;
   // Stage 1.
   logic signed [MW-1:0]         mprod_ff;
   logic signed [BPW-1:0]        bprod_ff;
   logic signed [BPW-1:0]        bbprod_ff;
   logic                         eta_hi_s1_ff;
   logic signed [DATA_WIDTH-1:0] p0_s1_ff;
   logic signed [KW-1:0]         b0_s1_ff;
   logic signed [KW-1:0]         bb0_s1_ff;
   // Stage 2.
   logic signed [CAL_W-1:0]      cal_b_ff;
   logic signed [CAL_W-1:0]      cal_bb_ff;

   logic signed [MCW-1:0]        mean_cal;
   logic                         force_half;
   logic signed [BRW-1:0]        braw;
   logic signed [BRW-1:0]        bbraw;
   logic signed [CAL_W-1:0]      cal_b_in;
   logic signed [CAL_W-1:0]      cal_bb_in;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         d_ff      <= signed'({1'b0, mistag}) - signed'({1'b0, mean_mistag});
         eta_hi_ff <= mistag >= HALF_Q14;
         p0_ff     <= offset;
         p1_ff     <= slope;
         b0_ff     <= (KW'(offset) <<< 1) + KW'(offset_delta);
         bb0_ff    <= (KW'(offset) <<< 1) - KW'(offset_delta);
         b1_ff     <= (KW'(slope) <<< 1) + KW'(slope_delta);
         bb1_ff    <= (KW'(slope) <<< 1) - KW'(slope_delta);
      end
      if (ld[1]) begin
         mprod_ff     <= MW'(p1_ff) * MW'(d_ff);
         bprod_ff     <= BPW'(b1_ff) * BPW'(d_ff);
         bbprod_ff    <= BPW'(bb1_ff) * BPW'(d_ff);
         eta_hi_s1_ff <= eta_hi_ff;
         p0_s1_ff     <= p0_ff;
         b0_s1_ff     <= b0_ff;
         bb0_s1_ff    <= bb0_ff;
      end
      if (ld[2]) begin
         cal_b_ff  <= cal_b_in;
         cal_bb_ff <= cal_bb_in;
      end
   end

   // The half-LSB rounding constant sits below the shifted offset bits.
   always_comb begin
      mean_cal   = (MCW'(p0_s1_ff) <<< 14) + MCW'(mprod_ff);
      force_half = eta_hi_s1_ff || (mean_cal >= MEAN_LIMIT);
      braw       = ((BRW'(b0_s1_ff) <<< 14) | BRW'(32'sd4096)) + BRW'(bprod_ff);
      bbraw      = ((BRW'(bb0_s1_ff) <<< 14) | BRW'(32'sd4096)) + BRW'(bbprod_ff);
      cal_b_in   = force_half ? HALF_Q16 : sat_cal(SAT_IN_W'(braw >>> 13));
      cal_bb_in  = force_half ? HALF_Q16 : sat_cal(SAT_IN_W'(bbraw >>> 13));
   end

   assign cal_b  = cal_b_ff;
   assign cal_bb = cal_bb_ff;

endmodule

// ===== rtl/core/tmc_front.sv =====
// ----------------------------------------------------------------------------
// Calibration segment
// Runs both taggers through their calibration stages in lockstep and carries
// the mode, decoded decisions, signed CP value and asymmetry alongside.
// ----------------------------------------------------------------------------
module tmc_front #(
   parameter int DATA_WIDTH = tmc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                i_valid,
   output logic                                i_ready,
   output logic                                o_valid,
   input  logic                                o_ready,
   input  tmc_pkg::mode_type                   mode,
   input  logic signed [1:0]                   os_decision,
   input  logic [tmc_pkg::MISTAG_W-1:0]        os_mistag,
   input  logic [tmc_pkg::MISTAG_W-1:0]        os_mean_mistag,
   input  logic signed [1:0]                   ss_decision,
   input  logic [tmc_pkg::MISTAG_W-1:0]        ss_mistag,
   input  logic [tmc_pkg::MISTAG_W-1:0]        ss_mean_mistag,
   input  logic signed [DATA_WIDTH-1:0]        cp_value,
   input  logic signed [DATA_WIDTH-1:0]        prod_asymmetry,
   input  logic signed [DATA_WIDTH-1:0]        os_offset,
   input  logic signed [DATA_WIDTH-1:0]        os_slope,
   input  logic signed [DATA_WIDTH-1:0]        os_offset_delta,
   input  logic signed [DATA_WIDTH-1:0]        os_slope_delta,
   input  logic signed [DATA_WIDTH-1:0]        ss_offset,
   input  logic signed [DATA_WIDTH-1:0]        ss_slope,
   input  logic signed [DATA_WIDTH-1:0]        ss_offset_delta,
   input  logic signed [DATA_WIDTH-1:0]        ss_slope_delta,
   output logic signed [tmc_pkg::CAL_W-1:0]    os_b,
   output logic signed [tmc_pkg::CAL_W-1:0]    os_bb,
   output logic signed [tmc_pkg::CAL_W-1:0]    ss_b,
   output logic signed [tmc_pkg::CAL_W-1:0]    ss_bb,
   output tmc_pkg::mode_type                   mode_o,
   output tmc_pkg::tag_sel_type                os_tag,
   output tmc_pkg::tag_sel_type                ss_tag,
   output logic signed [DATA_WIDTH:0]          cp_eff,
   output logic signed [DATA_WIDTH-1:0]        asym
);
   import tmc_pkg::*;

   localparam int STAGES = 3;

   logic [STAGES-1:0]            ld;
   mode_type                     mode_ff   [STAGES];
   tag_sel_type                  os_tag_ff [STAGES];
   tag_sel_type                  ss_tag_ff [STAGES];
   logic signed [DATA_WIDTH:0]   cp_ff     [STAGES];
   logic signed [DATA_WIDTH-1:0] asym_ff   [STAGES];
   logic signed [DATA_WIDTH:0]   cp_in;

   tmc_pipe_ctl #(
      .STAGES (STAGES)
   ) u_ctl (
      .clock   (clock),
      .reset   (reset),
      .i_valid (i_valid),
      .i_ready (i_ready),
      .o_valid (o_valid),
      .o_ready (o_ready),
      .ld      (ld)
   );

   tmc_calib #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_os (
      .clock        (clock),
      .ld           (ld),
      .mistag       (os_mistag),
      .mean_mistag  (os_mean_mistag),
      .offset       (os_offset),
      .slope        (os_slope),
      .offset_delta (os_offset_delta),
      .slope_delta  (os_slope_delta),
      .cal_b        (os_b),
      .cal_bb       (os_bb)
   );

   tmc_calib #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ss (
      .clock        (clock),
      .ld           (ld),
      .mistag       (ss_mistag),
      .mean_mistag  (ss_mean_mistag),
      .offset       (ss_offset),
      .slope        (ss_slope),
      .offset_delta (ss_offset_delta),
      .slope_delta  (ss_slope_delta),
      .cal_b        (ss_b),
      .cal_bb       (ss_bb)
   );

   // The sine coefficient carries a minus sign, folded into the CP value.
   assign cp_in = (mode == MODE_SIN) ? -((DATA_WIDTH + 1)'(cp_value))
                                     : (DATA_WIDTH + 1)'(cp_value);

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         mode_ff[0]   <= mode;
         os_tag_ff[0] <= decode_tag(os_decision);
         ss_tag_ff[0] <= decode_tag(ss_decision);
         cp_ff[0]     <= cp_in;
         asym_ff[0]   <= prod_asymmetry;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ld[k]) begin
            mode_ff[k]   <= mode_ff[k-1];
            os_tag_ff[k] <= os_tag_ff[k-1];
            ss_tag_ff[k] <= ss_tag_ff[k-1];
            cp_ff[k]     <= cp_ff[k-1];
            asym_ff[k]   <= asym_ff[k-1];
         end
      end
   end

   assign mode_o = mode_ff[STAGES-1];
   assign os_tag = os_tag_ff[STAGES-1];
   assign ss_tag = ss_tag_ff[STAGES-1];
   assign cp_eff = cp_ff[STAGES-1];
   assign asym   = asym_ff[STAGES-1];

endmodule

// ===== rtl/core/tmc_combine.sv =====
// ----------------------------------------------------------------------------
// Tagger combination segment
// Four stages: cross products, decision-independent terms, decision-weighted
// sum and difference in Q.32, then rounding to Q.23 with saturation.
// ----------------------------------------------------------------------------
module tmc_combine #(
   parameter int DATA_WIDTH = tmc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                i_valid,
   output logic                                i_ready,
   output logic                                o_valid,
   input  logic                                o_ready,
   input  logic signed [tmc_pkg::CAL_W-1:0]    os_b,
   input  logic signed [tmc_pkg::CAL_W-1:0]    os_bb,
   input  logic signed [tmc_pkg::CAL_W-1:0]    ss_b,
   input  logic signed [tmc_pkg::CAL_W-1:0]    ss_bb,
   input  tmc_pkg::mode_type                   mode,
   input  tmc_pkg::tag_sel_type                os_tag,
   input  tmc_pkg::tag_sel_type                ss_tag,
   input  logic signed [DATA_WIDTH:0]          cp_eff,
   input  logic signed [DATA_WIDTH-1:0]        asym,
   output logic signed [tmc_pkg::RES_W-1:0]    sum24,
   output logic signed [tmc_pkg::RES_W-1:0]    diff24,
   output tmc_pkg::mode_type                   mode_o,
   output logic signed [DATA_WIDTH:0]          cp_eff_o,
   output logic signed [DATA_WIDTH-1:0]        asym_o
);
   import tmc_pkg::*;

   localparam int STAGES = 4;
   localparam int PRW    = 2 * CAL_W;

   logic [STAGES-1:0]            ld;
   mode_type                     mode_ff   [STAGES];
   tag_sel_type                  os_tag_ff [STAGES];
   tag_sel_type                  ss_tag_ff [STAGES];
   tag_sel_type                  tt_ff     [STAGES];
   logic signed [DATA_WIDTH:0]   cp_ff     [STAGES];
   logic signed [DATA_WIDTH-1:0] asym_ff   [STAGES];

   // Stage D.
   logic signed [PRW-1:0]   ac_ff;
   logic signed [PRW-1:0]   be_ff;
   logic signed [CAL_W-1:0] a_ff;
   logic signed [CAL_W-1:0] b_ff;
   logic signed [CAL_W-1:0] c_ff;
   logic signed [CAL_W-1:0] e_ff;
   // Stage E.
   logic signed [MIX_W-1:0] t1_ff;
   logic signed [MIX_W-1:0] t2_ff;
   logic signed [MIX_W-1:0] uo_ff;
   logic signed [MIX_W-1:0] us_ff;
   logic signed [MIX_W-1:0] vo_ff;
   logic signed [MIX_W-1:0] vs_ff;
   // Stage F.
   logic signed [MIX_W-1:0] sum2_ff;
   logic signed [MIX_W-1:0] diff2_ff;
   // Stage G.
   logic signed [RES_W-1:0] sum24_ff;
   logic signed [RES_W-1:0] diff24_ff;

   logic signed [MIX_W-1:0] pos;
   logic signed [MIX_W-1:0] dos;
   logic signed [MIX_W-1:0] pss;
   logic signed [MIX_W-1:0] dss;
   logic signed [MIX_W-1:0] t1_in;
   logic signed [MIX_W-1:0] t2_in;
   logic signed [MIX_W-1:0] sum2_in;
   logic signed [MIX_W-1:0] diff2_in;
   tag_sel_type             tt_in;

   tmc_pipe_ctl #(
      .STAGES (STAGES)
   ) u_ctl (
      .clock   (clock),
      .reset   (reset),
      .i_valid (i_valid),
      .i_ready (i_ready),
      .o_valid (o_valid),
      .o_ready (o_ready),
      .ld      (ld)
   );

   assign tt_in = '{nonzero:  os_tag.nonzero && ss_tag.nonzero,
                    negative: os_tag.negative ^ ss_tag.negative};

   always_comb begin
      pos   = MIX_W'(a_ff) + MIX_W'(b_ff);
      dos   = MIX_W'(a_ff) - MIX_W'(b_ff);
      pss   = MIX_W'(c_ff) + MIX_W'(e_ff);
      dss   = MIX_W'(c_ff) - MIX_W'(e_ff);
      t1_in = ONE_Q32 + ((MIX_W'(ac_ff) + MIX_W'(be_ff)) <<< 1) - ((pos + pss) <<< 16);
      t2_in = ((MIX_W'(ac_ff) - MIX_W'(be_ff)) <<< 1) - ((dos + dss) <<< 16);
   end

   // Decisions of -1, 0 or +1 only select, negate or drop each term.
   always_comb begin
      sum2_in  = ONE_Q32 + apply_tag(tt_ff[1], t1_ff)
               + apply_tag(neg_tag(os_tag_ff[1]), uo_ff)
               + apply_tag(neg_tag(ss_tag_ff[1]), us_ff);
      diff2_in = apply_tag(tt_ff[1], t2_ff)
               + apply_tag(os_tag_ff[1], vo_ff)
               + apply_tag(ss_tag_ff[1], vs_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         ac_ff        <= PRW'(os_b) * PRW'(ss_b);
         be_ff        <= PRW'(os_bb) * PRW'(ss_bb);
         a_ff         <= os_b;
         b_ff         <= os_bb;
         c_ff         <= ss_b;
         e_ff         <= ss_bb;
         mode_ff[0]   <= mode;
         os_tag_ff[0] <= os_tag;
         ss_tag_ff[0] <= ss_tag;
         tt_ff[0]     <= tt_in;
         cp_ff[0]     <= cp_eff;
         asym_ff[0]   <= asym;
      end
      if (ld[1]) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         uo_ff <= dos <<< 16;
         us_ff <= dss <<< 16;
         vo_ff <= ONE_Q32 - (pos <<< 16);
         vs_ff <= ONE_Q32 - (pss <<< 16);
      end
      if (ld[2]) begin
         sum2_ff  <= sum2_in;
         diff2_ff <= diff2_in;
      end
      if (ld[3]) begin
         sum24_ff  <= sat_res(SAT_IN_W'((sum2_ff + MIX_W'(32'sd256)) >>> 9));
         diff24_ff <= sat_res(SAT_IN_W'((diff2_ff + MIX_W'(32'sd256)) >>> 9));
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ld[k]) begin
            mode_ff[k]   <= mode_ff[k-1];
            os_tag_ff[k] <= os_tag_ff[k-1];
            ss_tag_ff[k] <= ss_tag_ff[k-1];
            tt_ff[k]     <= tt_ff[k-1];
            cp_ff[k]     <= cp_ff[k-1];
            asym_ff[k]   <= asym_ff[k-1];
         end
      end
   end

   assign sum24    = sum24_ff;
   assign diff24   = diff24_ff;
   assign mode_o   = mode_ff[STAGES-1];
   assign cp_eff_o = cp_ff[STAGES-1];
   assign asym_o   = asym_ff[STAGES-1];

endmodule

// ===== rtl/core/tmc_scale.sv =====
// ----------------------------------------------------------------------------
// Asymmetry and CP scaling segment
// Five stages: asymmetry product, bracket, rounding to Q.23, CP product and
// final rounding to Q4.28 with saturation into the output register.
// ----------------------------------------------------------------------------
module tmc_scale #(
   parameter int DATA_WIDTH = tmc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                i_valid,
   output logic                                i_ready,
   output logic                                o_valid,
   input  logic                                o_ready,
   input  logic signed [tmc_pkg::RES_W-1:0]    sum24,
   input  logic signed [tmc_pkg::RES_W-1:0]    diff24,
   input  tmc_pkg::mode_type                   mode,
   input  logic signed [DATA_WIDTH:0]          cp_eff,
   input  logic signed [DATA_WIDTH-1:0]        asym,
   output logic signed [tmc_pkg::RES_W-1:0]    coefficient
);
   import tmc_pkg::*;

   localparam int STAGES = 5;
   localparam int PRW    = RES_W + DATA_WIDTH;
   localparam int XW     = ((PRW > 46) ? PRW : 46) + 2;
   localparam int PW     = RES_W + DATA_WIDTH + 2;
   localparam int CPS    = 3;

   logic [STAGES-1:0]          ld;
   logic signed [DATA_WIDTH:0] cp_ff [CPS];
   logic signed [PRW-1:0]      prod_ff;
   logic signed [RES_W-1:0]    other_ff;
   logic signed [XW-1:0]       x_ff;
   logic signed [RES_W-1:0]    x24_ff;
   logic signed [PW-1:0]       p_ff;
   logic signed [RES_W-1:0]    coef_ff;
   logic                       is_trig;

   tmc_pipe_ctl #(
      .STAGES (STAGES)
   ) u_ctl (
      .clock   (clock),
      .reset   (reset),
      .i_valid (i_valid),
      .i_ready (i_ready),
      .o_valid (o_valid),
      .o_ready (o_ready),
      .ld      (ld)
   );

   // Sine and cosine weight the sum by the asymmetry, sinh and cosh the
   // difference.
   assign is_trig = (mode == MODE_SIN) || (mode == MODE_COS);

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         prod_ff  <= PRW'(asym) * PRW'(is_trig ? sum24 : diff24);
         other_ff <= is_trig ? diff24 : sum24;
         cp_ff[0] <= cp_eff;
      end
      if (ld[1]) begin
         x_ff     <= ((XW'(other_ff) <<< 14) | XW'(32'sd8192)) - XW'(prod_ff);
         cp_ff[1] <= cp_ff[0];
      end
      if (ld[2]) begin
         x24_ff   <= sat_res(SAT_IN_W'(x_ff >>> 14));
         cp_ff[2] <= cp_ff[1];
      end
      if (ld[3]) begin
         p_ff <= PW'(x24_ff) * PW'(cp_ff[2]);
      end
      if (ld[4]) begin
         coef_ff <= sat_res(SAT_IN_W'((p_ff + PW'(32'sd1024)) >>> 11));
      end
   end

   assign coefficient = coef_ff;

endmodule

// ===== rtl/core/two_tagger_mistag_coefficient.sv =====
// Throughput: one word per cycle while the rsp side does not stall; each of the 12
// register stages holds one word and empty stages fill while the rsp side is stalled.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// calibration registers with their default values.
// ----------------------------------------------------------------------------
// Two-tagger mistag coefficient
// Calibrates the opposite-side and same-side mistags, combines them by their
// tag decisions and scales the result by asymmetry and CP value.
// ----------------------------------------------------------------------------
module two_tagger_mistag_coefficient #(
   parameter int DATA_WIDTH = tmc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: os_decision[2], os_mistag[15], os_mean_mistag[15],
   // ss_decision[2], ss_mistag[15], ss_mean_mistag[15],
   // cp_value[DATA_WIDTH], prod_asymmetry[DATA_WIDTH], zero fill.
   input  logic [((64 + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // From bit 0: mode[2].
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // From bit 0: coefficient[32].
   output logic [31:0]                          rsp_tdata,
   input  logic                                 csr_we,
   input  logic [tmc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [DATA_WIDTH-1:0]                csr_wdata
);
   import tmc_pkg::*;

   localparam int CP_LO   = 64;
   localparam int ASYM_LO = 64 + DATA_WIDTH;

   logic [DATA_WIDTH-1:0] cfg_ff [NUM_REGS];

   logic                         f_valid;
   logic                         f_ready;
   logic signed [CAL_W-1:0]      f_os_b;
   logic signed [CAL_W-1:0]      f_os_bb;
   logic signed [CAL_W-1:0]      f_ss_b;
   logic signed [CAL_W-1:0]      f_ss_bb;
   mode_type                     f_mode;
   tag_sel_type                  f_os_tag;
   tag_sel_type                  f_ss_tag;
   logic signed [DATA_WIDTH:0]   f_cp;
   logic signed [DATA_WIDTH-1:0] f_asym;

   logic                         c_valid;
   logic                         c_ready;
   logic signed [RES_W-1:0]      c_sum24;
   logic signed [RES_W-1:0]      c_diff24;
   mode_type                     c_mode;
   logic signed [DATA_WIDTH:0]   c_cp;
   logic signed [DATA_WIDTH-1:0] c_asym;

   logic signed [RES_W-1:0]      coefficient;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= CFG_RESET[i][DATA_WIDTH-1:0];
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   tmc_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .i_valid         (req_tvalid),
      .i_ready         (req_tready),
      .o_valid         (f_valid),
      .o_ready         (f_ready),
      .mode            (mode_type'(req_tuser)),
      .os_decision     (signed'(req_tdata[1:0])),
      .os_mistag       (req_tdata[16:2]),
      .os_mean_mistag  (req_tdata[31:17]),
      .ss_decision     (signed'(req_tdata[33:32])),
      .ss_mistag       (req_tdata[48:34]),
      .ss_mean_mistag  (req_tdata[63:49]),
      .cp_value        (signed'(req_tdata[CP_LO +: DATA_WIDTH])),
      .prod_asymmetry  (signed'(req_tdata[ASYM_LO +: DATA_WIDTH])),
      .os_offset       (signed'(cfg_ff[REG_OS_OFFSET])),
      .os_slope        (signed'(cfg_ff[REG_OS_SLOPE])),
      .os_offset_delta (signed'(cfg_ff[REG_OS_OFFSET_DELTA])),
      .os_slope_delta  (signed'(cfg_ff[REG_OS_SLOPE_DELTA])),
      .ss_offset       (signed'(cfg_ff[REG_SS_OFFSET])),
      .ss_slope        (signed'(cfg_ff[REG_SS_SLOPE])),
      .ss_offset_delta (signed'(cfg_ff[REG_SS_OFFSET_DELTA])),
      .ss_slope_delta  (signed'(cfg_ff[REG_SS_SLOPE_DELTA])),
      .os_b            (f_os_b),
      .os_bb           (f_os_bb),
      .ss_b            (f_ss_b),
      .ss_bb           (f_ss_bb),
      .mode_o          (f_mode),
      .os_tag          (f_os_tag),
      .ss_tag          (f_ss_tag),
      .cp_eff          (f_cp),
      .asym            (f_asym)
   );

   tmc_combine #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_combine (
      .clock    (clock),
      .reset    (reset),
      .i_valid  (f_valid),
      .i_ready  (f_ready),
      .o_valid  (c_valid),
      .o_ready  (c_ready),
      .os_b     (f_os_b),
      .os_bb    (f_os_bb),
      .ss_b     (f_ss_b),
      .ss_bb    (f_ss_bb),
      .mode     (f_mode),
      .os_tag   (f_os_tag),
      .ss_tag   (f_ss_tag),
      .cp_eff   (f_cp),
      .asym     (f_asym),
      .sum24    (c_sum24),
      .diff24   (c_diff24),
      .mode_o   (c_mode),
      .cp_eff_o (c_cp),
      .asym_o   (c_asym)
   );

   tmc_scale #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .i_valid     (c_valid),
      .i_ready     (c_ready),
      .o_valid     (rsp_tvalid),
      .o_ready     (rsp_tready),
      .sum24       (c_sum24),
      .diff24      (c_diff24),
      .mode        (c_mode),
      .cp_eff      (c_cp),
      .asym        (c_asym),
      .coefficient (coefficient)
   );

   assign rsp_tdata = coefficient;

endmodule
